// File: hdl/zrle_pkg.sv
// zrle_pkg: shared types and constants of the zero-run / literal byte encoder
// used by zrle_ctrl, zrle_dp and zero_run_literal_encoder; no dependencies
`default_nettype none

package zrle_pkg;

	localparam int unsigned MAX_LITERAL_DEF = 32;
	localparam logic [7:0] MIN_ZERO_RUN_RST = 8'd6;
	localparam logic [7:0] ZERO_RUN_CAP = 8'd255;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_ZFILL,
		ST_ADD_B,
		ST_EOD_CHK,
		ST_LIT_LO,
		ST_LIT_HI,
		ST_LIT_DATA,
		ST_ZRUN0,
		ST_ZRUN1,
		ST_ZRUN2,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		EMIT_CNT_LO,
		EMIT_CNT_HI,
		EMIT_LIT,
		EMIT_ZERO,
		EMIT_ZC
	} emit_sel_t;

	typedef struct packed {
		logic      load_in;
		logic      zc_inc;
		logic      zc_dec;
		logic      zc_clr;
		logic      lit_wr;
		logic      lit_zero;
		logic      lc_clr;
		logic      idx_clr;
		logic      idx_inc;
		logic      emit;
		emit_sel_t emit_sel;
		logic      finish;
	} cmd_t;

	typedef struct packed {
		logic zero_in;
		logic a_cond;
		logic lc_zero;
		logic zc_zero;
		logic zc_ge_thr;
		logic lit_full_next;
		logic idx_last;
		logic eod;
		logic emit_ok;
	} sts_t;

endpackage

`default_nettype wire

// File: hdl/zrle_ctrl.sv
// zrle_ctrl: encoder sequencer, one step per cycle unless output stalls
// depends on zrle_pkg; drives zrle_dp through cmd_t, reads sts_t
`default_nettype none

module zrle_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire zrle_pkg::sts_t sts,
	output zrle_pkg::cmd_t     cmd
);

	zrle_pkg::state_t state_q, state_d;
	zrle_pkg::state_t ret_q, ret_d;
	logic zfill_add_q, zfill_add_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= zrle_pkg::ST_IDLE;
			ret_q       <= zrle_pkg::ST_IDLE;
			zfill_add_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ret_q       <= ret_d;
			zfill_add_q <= zfill_add_d;
		end
	end

	// next state
	always_comb begin
		state_d     = state_q;
		ret_d       = ret_q;
		zfill_add_d = zfill_add_q;
		unique case (state_q)
			zrle_pkg::ST_IDLE: begin
				if (in_valid) state_d = zrle_pkg::ST_DECIDE;
			end
			zrle_pkg::ST_DECIDE: begin
				if (sts.zero_in) begin
					if (sts.a_cond && !sts.lc_zero) begin
						state_d = zrle_pkg::ST_LIT_LO;
						ret_d   = zrle_pkg::ST_EOD_CHK;
					end else if (sts.a_cond) begin
						state_d     = zrle_pkg::ST_ZFILL;
						zfill_add_d = 1'b0;
					end else begin
						state_d = zrle_pkg::ST_EOD_CHK;
					end
				end else if (!sts.zc_zero && sts.zc_ge_thr) begin
					state_d = zrle_pkg::ST_LIT_LO;
					ret_d   = zrle_pkg::ST_ZRUN0;
				end else if (!sts.zc_zero) begin
					state_d     = zrle_pkg::ST_ZFILL;
					zfill_add_d = 1'b1;
				end else begin
					state_d = zrle_pkg::ST_ADD_B;
				end
			end
			zrle_pkg::ST_ZFILL: begin
				if (sts.zc_zero) begin
					state_d = zfill_add_q ? zrle_pkg::ST_ADD_B : zrle_pkg::ST_EOD_CHK;
				end else if (sts.lit_full_next) begin
					state_d = zrle_pkg::ST_LIT_LO;
					ret_d   = zrle_pkg::ST_ZFILL;
				end
			end
			zrle_pkg::ST_ADD_B: begin
				if (sts.lit_full_next) begin
					state_d = zrle_pkg::ST_LIT_LO;
					ret_d   = zrle_pkg::ST_EOD_CHK;
				end else begin
					state_d = zrle_pkg::ST_EOD_CHK;
				end
			end
			zrle_pkg::ST_EOD_CHK: begin
				if (sts.eod) begin
					state_d = zrle_pkg::ST_LIT_LO;
					ret_d   = zrle_pkg::ST_FINISH;
				end else begin
					state_d = zrle_pkg::ST_FINISH;
				end
			end
			zrle_pkg::ST_LIT_LO: begin
				if (sts.lc_zero) state_d = ret_q;
				else if (sts.emit_ok) state_d = zrle_pkg::ST_LIT_HI;
			end
			zrle_pkg::ST_LIT_HI: begin
				if (sts.emit_ok) state_d = zrle_pkg::ST_LIT_DATA;
			end
			zrle_pkg::ST_LIT_DATA: begin
				if (sts.emit_ok && sts.idx_last) state_d = ret_q;
			end
			zrle_pkg::ST_ZRUN0: begin
				if (sts.emit_ok) state_d = zrle_pkg::ST_ZRUN1;
			end
			zrle_pkg::ST_ZRUN1: begin
				if (sts.emit_ok) state_d = zrle_pkg::ST_ZRUN2;
			end
			zrle_pkg::ST_ZRUN2: begin
				if (sts.emit_ok) state_d = zrle_pkg::ST_ADD_B;
			end
			zrle_pkg::ST_FINISH: begin
				if (sts.emit_ok) state_d = zrle_pkg::ST_IDLE;
			end
			default: state_d = zrle_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd          = '0;
		cmd.emit_sel = zrle_pkg::EMIT_ZERO;
		in_stall     = (state_q != zrle_pkg::ST_IDLE);
		unique case (state_q)
			zrle_pkg::ST_IDLE: begin
				cmd.load_in = in_valid;
			end
			zrle_pkg::ST_DECIDE: begin
				cmd.zc_inc = sts.zero_in;
			end
			zrle_pkg::ST_ZFILL: begin
				if (!sts.zc_zero) begin
					cmd.lit_wr   = 1'b1;
					cmd.lit_zero = 1'b1;
					cmd.zc_dec   = 1'b1;
				end
			end
			zrle_pkg::ST_ADD_B: begin
				cmd.lit_wr = 1'b1;
			end
			zrle_pkg::ST_EOD_CHK: begin
				cmd.zc_clr = sts.eod;
			end
			zrle_pkg::ST_LIT_LO: begin
				if (!sts.lc_zero && sts.emit_ok) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = zrle_pkg::EMIT_CNT_LO;
					cmd.idx_clr  = 1'b1;
				end
			end
			zrle_pkg::ST_LIT_HI: begin
				cmd.emit     = sts.emit_ok;
				cmd.emit_sel = zrle_pkg::EMIT_CNT_HI;
			end
			zrle_pkg::ST_LIT_DATA: begin
				cmd.emit     = sts.emit_ok;
				cmd.emit_sel = zrle_pkg::EMIT_LIT;
				cmd.idx_inc  = sts.emit_ok;
				cmd.lc_clr   = sts.emit_ok && sts.idx_last;
			end
			zrle_pkg::ST_ZRUN0, zrle_pkg::ST_ZRUN1: begin
				cmd.emit     = sts.emit_ok;
				cmd.emit_sel = zrle_pkg::EMIT_ZERO;
			end
			zrle_pkg::ST_ZRUN2: begin
				cmd.emit     = sts.emit_ok;
				cmd.emit_sel = zrle_pkg::EMIT_ZC;
				cmd.zc_clr   = sts.emit_ok;
			end
			zrle_pkg::ST_FINISH: begin
				cmd.finish = sts.emit_ok;
			end
			default: begin
				cmd.finish = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: hdl/zrle_dp.sv
// zrle_dp: datapath of the encoder: literal buffer, counters, threshold
// register, output hold stage; depends on zrle_pkg, driven by zrle_ctrl
`default_nettype none

module zrle_dp #(
	parameter int unsigned MAX_LITERAL = zrle_pkg::MAX_LITERAL_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire zrle_pkg::cmd_t cmd,
	output zrle_pkg::sts_t  sts,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_data,
	input  wire logic       cfg_write,
	input  wire logic [7:0] cfg_data,
	input  wire logic       out_stall,
	output logic            out_valid,
	output logic [7:0]      out_byte,
	output logic            last_of_item
);

	localparam int unsigned CW = $clog2(MAX_LITERAL + 1);
	localparam int unsigned AW = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_LITERAL);
	localparam logic [9:0] MAX_W = 10'(MAX_LITERAL);

	logic [7:0]    mem [MAX_LITERAL];
	logic [7:0]    rd_q;
	logic [AW-1:0] rd_addr;
	logic [CW-1:0] idx_nxt;

	logic [7:0]    b_q;
	logic          eod_q;
	logic [7:0]    thr_q;
	logic [CW-1:0] lc_q;
	logic [7:0]    zc_q;
	logic [AW-1:0] idx_q;

	logic          hold_valid_q;
	logic [7:0]    hold_byte_q;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_last_q;

	logic          out_free;
	logic [7:0]    emit_byte;
	logic [8:0]    zc1;

	assign zc1     = {1'b0, zc_q} + 9'd1;
	assign idx_nxt = CW'(idx_q) + CW'(1);
	assign rd_addr = (cmd.idx_inc && (idx_nxt < MAX_C)) ? idx_nxt[AW-1:0] :
	                 cmd.idx_inc ? '0 : idx_q;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		sts.zero_in       = (b_q == 8'd0) && (zc_q != zrle_pkg::ZERO_RUN_CAP);
		sts.a_cond        = (zc1 < {1'b0, thr_q}) &&
		                    ((10'(lc_q) + {1'b0, zc1}) >= MAX_W);
		sts.lc_zero       = (lc_q == '0);
		sts.zc_zero       = (zc_q == 8'd0);
		sts.zc_ge_thr     = (zc_q >= thr_q);
		sts.lit_full_next = ((lc_q + CW'(1)) == MAX_C);
		sts.idx_last      = (idx_nxt == lc_q);
		sts.eod           = eod_q;
		sts.emit_ok       = !hold_valid_q || out_free;
	end

	always_comb begin
		unique case (cmd.emit_sel)
			zrle_pkg::EMIT_CNT_LO: emit_byte = 8'(lc_q);
			zrle_pkg::EMIT_CNT_HI: emit_byte = 8'd0;
			zrle_pkg::EMIT_LIT:    emit_byte = rd_q;
			zrle_pkg::EMIT_ZERO:   emit_byte = 8'd0;
			zrle_pkg::EMIT_ZC:     emit_byte = zc_q;
			default:               emit_byte = 8'd0;
		endcase
	end

	// literal buffer
	always_ff @(posedge clk) begin
		if (cmd.lit_wr) mem[lc_q[AW-1:0]] <= cmd.lit_zero ? 8'd0 : b_q;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			b_q   <= data_byte;
			eod_q <= end_of_data;
		end
		if (cmd.emit) hold_byte_q <= emit_byte;
		if (hold_valid_q && (cmd.emit || cmd.finish)) begin
			out_byte_q <= hold_byte_q;
			out_last_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q        <= zrle_pkg::MIN_ZERO_RUN_RST;
			lc_q         <= '0;
			zc_q         <= 8'd0;
			idx_q        <= '0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_write) thr_q <= cfg_data;

			if (cmd.lc_clr) lc_q <= '0;
			else if (cmd.lit_wr) lc_q <= lc_q + CW'(1);

			if (cmd.zc_clr) zc_q <= 8'd0;
			else if (cmd.zc_inc) zc_q <= zc1[7:0];
			else if (cmd.zc_dec) zc_q <= zc_q - 8'd1;

			if (cmd.idx_clr) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_nxt[AW-1:0];

			if (cmd.emit) hold_valid_q <= 1'b1;
			else if (cmd.finish) hold_valid_q <= 1'b0;

			if (hold_valid_q && (cmd.emit || cmd.finish)) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign last_of_item = out_last_q;

endmodule

`default_nettype wire

// File: hdl/zero_run_literal_encoder.sv
// Zero-run / literal encoder: top level joining the sequencer and the datapath
// depends on zrle_pkg, zrle_ctrl and zrle_dp
//
// Bytes in, encoded bytes out: literal blocks (count low byte, count high
// byte, bytes) and zero-run blocks (0, 0, length). One item is taken at a
// time. Each accepted item is decided on, then either extends the zero run
// or puts a byte into the literal buffer, and ends with an end-of-data check
// and a finish step before the next item can be accepted. Zeros of a short
// run are moved into the literal buffer one at a time; a flush with no
// literals pending, before a zero-run block or at end of data, sends nothing.
// Every step that sends a byte waits while the output is stalled. The last
// byte of an item is kept in the output hold stage until the item finishes,
// so it can carry last_of_item. min_zero_run resets to 6.
`default_nettype none

module zero_run_literal_encoder #(
	parameter int unsigned MAX_LITERAL = zrle_pkg::MAX_LITERAL_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_data,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            last_of_item,
	input  wire logic       cfg_write,
	input  wire logic [7:0] cfg_data
);

	zrle_pkg::cmd_t cmd;
	zrle_pkg::sts_t sts;

	zrle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	zrle_dp #(
		.MAX_LITERAL (MAX_LITERAL)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.data_byte    (data_byte),
		.end_of_data  (end_of_data),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.out_byte     (out_byte),
		.last_of_item (last_of_item)
	);

endmodule

`default_nettype wire
